// ===== sv/generational_handle_allocator_assert.svh =====
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GHA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("generational handle allocator check failed");

// next-cycle implication, checked outside reset
`define GHA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("generational handle allocator check failed");

`endif

// ===== sv/ghalloc_pkg.sv =====
package ghalloc_pkg;

   localparam int MAX_ENTITIES_DEF = 1024;
   localparam int OP_W             = 2;
   localparam int ID_W             = 10;
   localparam int VER_W            = 16;
   localparam int STATUS_W         = 2;

   localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
   localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
   localparam logic [OP_W-1:0] OP_CHECK   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DEAD = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic accept;
      logic clear;
      logic lookup;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } stat_type;

endpackage

// ===== sv/ghalloc_ctrl.sv =====
module ghalloc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output ghalloc_pkg::cmd_type  cmd,
   input  ghalloc_pkg::stat_type stat
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CLEAR = 2'd1;
   localparam logic [1:0] ST_READ  = 2'd2;
   localparam logic [1:0] ST_EXEC  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = ST_READ;
            end
         end
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.lookup = 1'b1;
            state_in   = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== sv/ghalloc_dp.sv =====
module ghalloc_dp #(
   parameter int MAX_ENTITIES = ghalloc_pkg::MAX_ENTITIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ghalloc_pkg::cmd_type                cmd,
   output ghalloc_pkg::stat_type               stat,
   input  logic [ghalloc_pkg::OP_W-1:0]        req_op,
   input  logic [ghalloc_pkg::ID_W-1:0]        req_entity_id,
   input  logic [ghalloc_pkg::VER_W-1:0]       req_entity_version,
   output logic                                rsp_strobe,
   output logic [ghalloc_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ghalloc_pkg::ID_W-1:0]        rsp_handle_id,
   output logic [ghalloc_pkg::VER_W-1:0]       rsp_handle_version,
   output logic                                rsp_is_alive,
   output logic                                rsp_is_valid
);

   localparam int IdxW = $clog2(MAX_ENTITIES);
   localparam int CntW = $clog2(MAX_ENTITIES + 1);
   localparam int IdW  = ghalloc_pkg::ID_W;
   localparam int VerW = ghalloc_pkg::VER_W;
   localparam int EntW = VerW + 1;
   localparam logic [CntW-1:0] MaxCnt  = CntW'(MAX_ENTITIES);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_ENTITIES - 1);

   logic [ghalloc_pkg::OP_W-1:0] op_ff;
   logic [IdW-1:0]               id_ff;
   logic [VerW-1:0]              ver_ff;

   logic [CntW-1:0] free_count_ff;
   logic [CntW-1:0] free_count_in;
   logic [CntW-1:0] next_fresh_ff;
   logic [CntW-1:0] next_fresh_in;
   logic [IdxW-1:0] clear_ff;

   logic [IdxW-1:0] stack_mem_ff [MAX_ENTITIES];
   logic [IdxW-1:0] stack_q_ff;
   logic [IdxW-1:0] pop_idx;
   logic [CntW-1:0] pop_cnt;
   logic            push;

   logic [EntW-1:0] ent_mem_ff [MAX_ENTITIES];
   logic [EntW-1:0] ent_q_ff;
   logic [EntW-1:0] ent_wd;
   logic [IdxW-1:0] ent_wa;
   logic            ent_we;

   logic [IdxW-1:0] tgt_ff;
   logic [IdxW-1:0] tgt_in;
   logic            tgt_ok_ff;
   logic            tgt_ok_in;
   logic            full_ff;
   logic            full_in;
   logic            in_range;

   logic            cur_alive;
   logic [VerW-1:0] cur_gen;
   logic [VerW-1:0] bump_gen;
   logic            is_create;
   logic            is_destroy;

   logic                             rsp_strobe_ff;
   logic [ghalloc_pkg::STATUS_W-1:0] status_ff;
   logic [ghalloc_pkg::STATUS_W-1:0] status_in;
   logic [IdW-1:0]                   hid_ff;
   logic [IdW-1:0]                   hid_in;
   logic [VerW-1:0]                  hver_ff;
   logic [VerW-1:0]                  hver_in;
   logic                             alive_ff;
   logic                             alive_in;
   logic                             valid_ff;
   logic                             valid_in;

   assign stat.clear_last = (clear_ff == LastIdx);

   assign is_create  = (op_ff == ghalloc_pkg::OP_CREATE);
   assign is_destroy = (op_ff == ghalloc_pkg::OP_DESTROY);
   assign in_range   = (17'(id_ff) < 17'(MAX_ENTITIES));

   // capture the request
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_op;
         id_ff  <= req_entity_id;
         ver_ff <= req_entity_version;
      end
   end

   // pick the target identifier
   always_comb begin
      tgt_in        = tgt_ff;
      tgt_ok_in     = tgt_ok_ff;
      full_in       = full_ff;
      free_count_in = free_count_ff;
      next_fresh_in = next_fresh_ff;
      if (cmd.lookup) begin
         full_in = 1'b0;
         if (is_create) begin
            tgt_ok_in = 1'b1;
            if (free_count_ff != '0) begin
               tgt_in        = stack_q_ff;
               free_count_in = free_count_ff - CntW'(1);
            end else if (next_fresh_ff < MaxCnt) begin
               tgt_in        = next_fresh_ff[IdxW-1:0];
               next_fresh_in = next_fresh_ff + CntW'(1);
            end else begin
               tgt_ok_in = 1'b0;
               full_in   = 1'b1;
            end
         end else begin
            tgt_in    = IdxW'(id_ff);
            tgt_ok_in = in_range;
         end
      end else if (cmd.commit && push) begin
         free_count_in = free_count_ff + CntW'(1);
      end
   end

   assign cur_alive = tgt_ok_ff & ent_q_ff[VerW];
   assign cur_gen   = tgt_ok_ff ? ent_q_ff[VerW-1:0] : '0;
   assign bump_gen  = cur_gen + VerW'(1);
   assign push      = is_destroy && cur_alive && (free_count_ff < MaxCnt);

   // free stack: pop address is one below the count, registered read every cycle
   assign pop_cnt = free_count_ff - CntW'(1);
   assign pop_idx = pop_cnt[IdxW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.commit && push) begin
         stack_mem_ff[free_count_ff[IdxW-1:0]] <= tgt_ff;
      end
      stack_q_ff <= stack_mem_ff[pop_idx];
   end

   // entity table: alive bit over generation
   always_comb begin
      ent_we = 1'b0;
      ent_wa = tgt_ff;
      ent_wd = '0;
      if (cmd.clear) begin
         ent_we = 1'b1;
         ent_wa = clear_ff;
      end else if (cmd.commit) begin
         if (is_create && !full_ff) begin
            ent_we = 1'b1;
            ent_wd = {1'b1, cur_gen};
         end else if (is_destroy && cur_alive) begin
            ent_we = 1'b1;
            ent_wd = {1'b0, bump_gen};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem_ff[ent_wa] <= ent_wd;
      end
      ent_q_ff <= ent_mem_ff[tgt_in];
   end

   // form the result
   always_comb begin
      status_in = ghalloc_pkg::STATUS_OK;
      hid_in    = id_ff;
      hver_in   = cur_gen;
      alive_in  = 1'b0;
      valid_in  = 1'b0;
      if (is_create) begin
         if (full_ff) begin
            status_in = ghalloc_pkg::STATUS_FULL;
            hid_in    = '0;
            hver_in   = '0;
         end else begin
            hid_in = IdW'(tgt_ff);
         end
      end else if (is_destroy) begin
         if (cur_alive) begin
            hver_in = bump_gen;
         end else begin
            status_in = ghalloc_pkg::STATUS_DEAD;
         end
      end else begin
         alive_in = cur_alive;
         valid_in = cur_alive && (cur_gen == ver_ff);
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff    <= tgt_in;
      tgt_ok_ff <= tgt_ok_in;
      full_ff   <= full_in;
      if (cmd.commit) begin
         status_ff <= status_in;
         hid_ff    <= hid_in;
         hver_ff   <= hver_in;
         alive_ff  <= alive_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= '0;
         next_fresh_ff <= '0;
         clear_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         free_count_ff <= free_count_in;
         next_fresh_ff <= next_fresh_in;
         rsp_strobe_ff <= cmd.commit;
         if (cmd.clear) begin
            clear_ff <= clear_ff + IdxW'(1);
         end
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_handle_id      = hid_ff;
   assign rsp_handle_version = hver_ff;
   assign rsp_is_alive       = alive_ff;
   assign rsp_is_valid       = valid_ff;

endmodule

// ===== sv/generational_handle_allocator.sv =====
// channel   | ports                                              | transfer
// ----------+----------------------------------------------------+---------------------------
// request   | req_op, req_entity_id, req_entity_version          | start high while busy low
// response  | rsp_status, rsp_handle_id, rsp_handle_version,     | rsp_strobe high, one cycle
//           | rsp_is_alive, rsp_is_valid                         |
//
// Each item passes through accept, lookup and commit; the result strobes in the cycle after
// commit, when busy is already low, so a new item is accepted only after the last is committed.
// The lookup step is set by the registered reads of the free stack and the entity table.
// After reset a clearing pass writes every entity table entry, with busy high.
// Results cannot be stalled; each is shown for exactly one cycle.
module generational_handle_allocator #(
   parameter int MAX_ENTITIES = ghalloc_pkg::MAX_ENTITIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [ghalloc_pkg::OP_W-1:0]     req_op,
   input  logic [ghalloc_pkg::ID_W-1:0]     req_entity_id,
   input  logic [ghalloc_pkg::VER_W-1:0]    req_entity_version,
   output logic                             rsp_strobe,
   output logic [ghalloc_pkg::STATUS_W-1:0] rsp_status,
   output logic [ghalloc_pkg::ID_W-1:0]     rsp_handle_id,
   output logic [ghalloc_pkg::VER_W-1:0]    rsp_handle_version,
   output logic                             rsp_is_alive,
   output logic                             rsp_is_valid
);

   ghalloc_pkg::cmd_type  cmd;
   ghalloc_pkg::stat_type stat;

   ghalloc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   ghalloc_dp #(
      .MAX_ENTITIES (MAX_ENTITIES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_op             (req_op),
      .req_entity_id      (req_entity_id),
      .req_entity_version (req_entity_version),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_handle_id      (rsp_handle_id),
      .rsp_handle_version (rsp_handle_version),
      .rsp_is_alive       (rsp_is_alive),
      .rsp_is_valid       (rsp_is_valid)
   );

`include "generational_handle_allocator_assert.svh"

   `GHA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `GHA_ASSERT_NEXT(a_single_strobe, rsp_strobe, !rsp_strobe)
   `GHA_ASSERT_NOW(a_strobe_idle, rsp_strobe, !busy)
   `GHA_ASSERT_NOW(a_valid_alive, rsp_strobe && rsp_is_valid, rsp_is_alive)

endmodule
